[hdl/solq_pkg.sv]
// Shared types, codes and sizes of the sorted open-list queue.
package solq_pkg;

  localparam int DEPTH    = 64;
  localparam int KEY_BITS = 16;
  localparam int NODE_W   = 16;
  localparam int COST_W   = 32;
  localparam int HNDL_W   = 16;
  localparam int CNT_W    = $clog2(DEPTH + 1);

  localparam logic [NODE_W-1:0] KEY_MASK = NODE_W'((33'h1 << KEY_BITS) - 33'h1);

  // request codes
  localparam logic [2:0] REQ_ADD    = 3'd0;
  localparam logic [2:0] REQ_REMOVE = 3'd1;
  localparam logic [2:0] REQ_FIND   = 3'd2;
  localparam logic [2:0] REQ_POP    = 3'd3;
  localparam logic [2:0] REQ_CLEAR  = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_MISS  = 2'd3;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [NODE_W-1:0] node_id;
    logic [COST_W-1:0] cost;
    logic [HNDL_W-1:0] record_handle;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              found;
    logic [NODE_W-1:0] out_node_id;
    logic [COST_W-1:0] out_cost;
    logic [HNDL_W-1:0] out_handle;
    logic [CNT_W-1:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [COST_W-1:0] cost;
    logic [HNDL_W-1:0] handle;
  } ent_t;

  typedef enum logic [1:0] {
    RES_NONE = 2'd0,
    RES_NEW  = 2'd1,
    RES_HIT  = 2'd2,
    RES_HEAD = 2'd3
  } res_sel_t;

  typedef struct packed {
    logic       latch;
    logic       compare;
    logic       rm_match;
    logic       rm_head;
    logic       insert;
    logic       clear;
    logic       res_load;
    logic       out_load;
    res_sel_t   res_sel;
    logic [1:0] res_status;
    logic       res_found;
  } cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       hit;
    logic       empty;
    logic       full;
    logic       out_free;
  } sts_t;

endpackage

[hdl/sorted_open_list_queue.sv]
// Top level of the sorted open-list queue: controller and datapath.
//
//  channel | ports                          | payload
//  --------+--------------------------------+------------------------------
//  request | in_valid, in_ready, in_data    | req_t: type, node, cost, handle
//  result  | out_valid, out_ready, out_data | rsp_t: status, found, entry, count
//
// An item goes from accept to result register through load, parallel compare
// over all cells, decide and shift, and result hand-off. An add that replaces a
// present node also has the cells shift out the old entry and compare again before the insert.
// Reset clears the entry count and the controller; cells hold no reset value.
// A result waits in the output register; the next item is accepted meanwhile
// and its hand-off step holds until out_ready takes the waiting result.
module sorted_open_list_queue import solq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_data
);

  cmd_t cmd;
  sts_t sts;

  solq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  solq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_ready (out_ready),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[hdl/solq_dp.sv]
// Datapath: sorted entry cells, parallel compare, shift update and result registers.
module solq_dp import solq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cmd_t cmd,
  input  req_t in_data,
  input  logic out_ready,
  output sts_t sts,
  output logic out_valid,
  output rsp_t out_data
);

  req_t              req_r;
  ent_t              ent_r   [DEPTH];
  ent_t              ent_nxt [DEPTH];
  ent_t              next_ent[DEPTH];
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [DEPTH-1:0]  match_r, ge_r, lt_r;
  logic [DEPTH-1:0]  match_c, ge_c, lt_c;
  logic [DEPTH-1:0]  ins_v, ins_prev;
  logic [1:0]        res_status_r;
  logic              res_found_r;
  ent_t              res_ent_r, res_ent_nxt;
  logic              out_valid_r;
  rsp_t              out_r;
  ent_t              new_ent, hit_ent;

  assign new_ent.node   = req_r.node_id & KEY_MASK;
  assign new_ent.cost   = req_r.cost;
  assign new_ent.handle = req_r.record_handle;

  // neighbor taps for the left shift
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_tap
    if (gi < DEPTH - 1) begin : g_mid
      assign next_ent[gi] = ent_r[gi+1];
    end else begin : g_last
      assign next_ent[gi] = ent_r[gi];
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match_c[i] = (CNT_W'(i) < count_r) && (ent_r[i].node == new_ent.node);
      lt_c[i]    = (CNT_W'(i) < count_r) && (req_r.cost < ent_r[i].cost);
    end
    // cells at and behind the matching cell
    for (int i = 0; i < DEPTH; i++) begin
      ge_c[i] = 1'b0;
      for (int j = 0; j < DEPTH; j++) begin
        if (j <= i) ge_c[i] = ge_c[i] | match_c[j];
      end
    end
  end

  always_comb begin
    hit_ent = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (match_r[i]) hit_ent = hit_ent | ent_r[i];
    end
  end

  // insertion span: cells from the sorted place up to the first free cell past the tail
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ins_v[i] = lt_r[i] || (CNT_W'(i) == count_r);
    end
  end
  assign ins_prev = {ins_v[DEPTH-2:0], 1'b0};

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ent_nxt[i] = ent_r[i];
      if ((cmd.rm_match && ge_r[i]) || cmd.rm_head) begin
        ent_nxt[i] = next_ent[i];
      end else if (cmd.insert && ins_v[i]) begin
        if (ins_prev[i]) begin
          ent_nxt[i] = ent_r[(i > 0) ? i - 1 : 0];
        end else begin
          ent_nxt[i] = new_ent;
        end
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.clear) begin
      count_nxt = '0;
    end else if (cmd.rm_match || cmd.rm_head) begin
      count_nxt = count_r - CNT_W'(1);
    end else if (cmd.insert) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_comb begin
    unique case (cmd.res_sel)
      RES_NEW:  res_ent_nxt = new_ent;
      RES_HIT:  res_ent_nxt = hit_ent;
      RES_HEAD: res_ent_nxt = ent_r[0];
      default:  res_ent_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) ent_r[i] <= ent_nxt[i];
    if (cmd.latch) req_r <= in_data;
    if (cmd.res_load) begin
      res_status_r <= cmd.res_status;
      res_found_r  <= cmd.res_found;
      res_ent_r    <= res_ent_nxt;
    end
    if (cmd.out_load) begin
      out_r.status      <= res_status_r;
      out_r.found       <= res_found_r;
      out_r.out_node_id <= res_ent_r.node;
      out_r.out_cost    <= res_ent_r.cost;
      out_r.out_handle  <= res_ent_r.handle;
      out_r.entry_count <= count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      match_r     <= '0;
      ge_r        <= '0;
      lt_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.compare) begin
        match_r <= match_c;
        ge_r    <= ge_c;
        lt_r    <= lt_c;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.req_type = req_r.req_type;
  assign sts.hit      = |match_r;
  assign sts.empty    = (count_r == '0);
  assign sts.full     = (count_r == CNT_W'(DEPTH));
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_unique_node: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_r))
    else $error("node held in more than one cell");

  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |-> !sts.full)
    else $error("insert into a full list");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not advance the count");

  a_remove_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rm_match |-> (sts.hit && !sts.empty))
    else $error("remove without a matching cell");
`endif

endmodule

[hdl/solq_ctrl.sv]
// Controller: sequences compare, decide, insert and result hand-off for each item.
module solq_ctrl import solq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CMP   = 6'b000010,
    S_DEC   = 6'b000100,
    S_RECMP = 6'b001000,
    S_INS   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.res_sel    = RES_NONE;
    cmd.res_status = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmd.compare = 1'b1;
        state_nxt   = S_DEC;
      end
      S_DEC: begin
        cmd.res_load = 1'b1;
        state_nxt    = S_DONE;
        unique case (sts.req_type)
          REQ_ADD: begin
            if (sts.hit) begin
              // drop the old entry, then re-sort the new one in
              cmd.rm_match  = 1'b1;
              cmd.res_found = 1'b1;
              cmd.res_sel   = RES_NEW;
              state_nxt     = S_RECMP;
            end else if (sts.full) begin
              cmd.res_status = ST_FULL;
            end else begin
              cmd.insert  = 1'b1;
              cmd.res_sel = RES_NEW;
            end
          end
          REQ_REMOVE: begin
            if (sts.empty) begin
              cmd.res_status = ST_EMPTY;
            end else if (!sts.hit) begin
              cmd.res_status = ST_MISS;
            end else begin
              cmd.rm_match  = 1'b1;
              cmd.res_found = 1'b1;
              cmd.res_sel   = RES_HIT;
            end
          end
          REQ_FIND: begin
            if (sts.hit) begin
              cmd.res_found = 1'b1;
              cmd.res_sel   = RES_HIT;
            end else begin
              cmd.res_status = ST_MISS;
            end
          end
          REQ_POP: begin
            if (sts.empty) begin
              cmd.res_status = ST_EMPTY;
            end else begin
              cmd.rm_head = 1'b1;
              cmd.res_sel = RES_HEAD;
            end
          end
          REQ_CLEAR: begin
            cmd.clear = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_RECMP: begin
        cmd.compare = 1'b1;
        state_nxt   = S_INS;
      end
      S_INS: begin
        cmd.insert = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        // hold until the output register frees up
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

[sim/sorted_open_list_queue_check.sv]
// Checker for the sorted open-list queue: predicts each result and compares it.
module sorted_open_list_queue_check import solq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  req_t in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  rsp_t out_data,
  output int   fail_count,
  output int   pending,
  output int   compared_count
);
  timeunit 1ns;
  timeprecision 1ps;

  ent_t slots [DEPTH];
  int   fill = 0;
  rsp_t expected_q [$];
  int   errs = 0;
  int   checked = 0;

  initial begin
    fail_count = 0;
    pending = 0;
    compared_count = 0;
  end

  task automatic report_mismatch(input string what, input logic [$bits(rsp_t)-1:0] got,
                                 input logic [$bits(rsp_t)-1:0] want);
    errs++;
    $display("%0t ns: result %0d, %s: got 0x%0h, want 0x%0h", $time, checked, what, got, want);
  endtask

  function automatic int find_slot(input logic [NODE_W-1:0] key);
    for (int i = 0; i < fill; i++) begin
      if (slots[i].node == key) return i;
    end
    return -1;
  endfunction

  function automatic void drop_slot(input int pos);
    for (int i = pos; i < fill - 1; i++) slots[i] = slots[i + 1];
    fill--;
  endfunction

  // Place behind every entry of equal cost: first slot with a strictly higher cost.
  function automatic void insert_sorted(input ent_t e);
    int pos;
    pos = fill;
    for (int i = fill - 1; i >= 0; i--) begin
      if (e.cost < slots[i].cost) pos = i;
    end
    for (int i = fill; i > pos; i--) slots[i] = slots[i - 1];
    slots[pos] = e;
    fill++;
  endfunction

  function automatic rsp_t predict_result(input req_t r);
    rsp_t res;
    ent_t e;
    ent_t hit;
    int   pos;
    res = '0;
    e.node = r.node_id & KEY_MASK;
    e.cost = r.cost;
    e.handle = r.record_handle;
    pos = find_slot(e.node);
    hit = (pos >= 0) ? slots[pos] : '0;
    case (r.req_type)
      REQ_ADD: begin
        if (pos < 0 && fill >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // replace: take the old entry out and sort the new one in
          if (pos >= 0) begin
            drop_slot(pos);
            res.found = 1'b1;
          end
          insert_sorted(e);
          res.out_node_id = e.node;
          res.out_cost = e.cost;
          res.out_handle = e.handle;
        end
      end
      REQ_REMOVE: begin
        if (fill == 0) begin
          res.status = ST_EMPTY;
        end else if (pos < 0) begin
          res.status = ST_MISS;
        end else begin
          res.found = 1'b1;
          res.out_node_id = hit.node;
          res.out_cost = hit.cost;
          res.out_handle = hit.handle;
          drop_slot(pos);
        end
      end
      REQ_FIND: begin
        if (pos < 0) begin
          res.status = ST_MISS;
        end else begin
          res.found = 1'b1;
          res.out_node_id = hit.node;
          res.out_cost = hit.cost;
          res.out_handle = hit.handle;
        end
      end
      REQ_POP: begin
        if (fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.out_node_id = slots[0].node;
          res.out_cost = slots[0].cost;
          res.out_handle = slots[0].handle;
          drop_slot(0);
        end
      end
      REQ_CLEAR: fill = 0;
      default: ;
    endcase
    res.entry_count = CNT_W'(fill);
    return res;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (!rst_n) begin
      fill = 0;
      expected_q.delete();
    end else begin
      // retire the result first: it always belongs to an earlier item
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing expected", out_data, '0);
        end else begin
          want = expected_q.pop_front();
          if (out_data.status !== want.status)
            report_mismatch("status", out_data.status, want.status);
          if (out_data.found !== want.found)
            report_mismatch("found", out_data.found, want.found);
          if (out_data.out_node_id !== want.out_node_id)
            report_mismatch("node id", out_data.out_node_id, want.out_node_id);
          if (out_data.out_cost !== want.out_cost)
            report_mismatch("cost", out_data.out_cost, want.out_cost);
          if (out_data.out_handle !== want.out_handle)
            report_mismatch("handle", out_data.out_handle, want.out_handle);
          if (out_data.entry_count !== want.entry_count)
            report_mismatch("entry count", out_data.entry_count, want.entry_count);
          checked++;
        end
      end
      // queue the prediction behind the ones still waiting
      if (in_valid && in_ready) expected_q = {expected_q, predict_result(in_data)};
    end
    fail_count <= errs;
    pending <= expected_q.size();
    compared_count <= checked;
  end

endmodule

[sim/sorted_open_list_queue_test.sv]
// Testbench top for the sorted open-list queue: stimulus, stalls and verdict.
module sorted_open_list_queue_test;
  timeunit 1ns;
  timeprecision 1ps;
  import solq_pkg::*;

  localparam int ITEM_TARGET = 1150;
  localparam int LONG_HOLD   = 400;
  localparam int NODE_POOL   = 128;
  localparam int DRAIN_LIMIT = 5000;
  localparam int SETTLE      = 20;

  // request codes the block treats as no operation
  localparam logic [2:0] REQ_SPARE_A = 3'd5;
  localparam logic [2:0] REQ_SPARE_B = 3'd6;
  localparam logic [2:0] REQ_SPARE_C = 3'd7;

  typedef enum int {SEG_FILL, SEG_MIXED, SEG_DRAIN} seg_kind_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;

  logic hold_req = 1'b0;
  logic hold_served = 1'b0;
  int   hold_left = 0;
  int   in_idle_pct = 0;
  int   out_idle_pct = 0;

  int   sent = 0;
  int   op_seen [8];
  int   fail_count;
  int   pending;
  int   compared_count;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  sorted_open_list_queue dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  sorted_open_list_queue_check checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .compared_count(compared_count)
  );

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_served) begin
      hold_served <= 1'b1;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  function automatic req_t make_req(input logic [2:0] op, input logic [NODE_W-1:0] node,
                                    input logic [COST_W-1:0] cost,
                                    input logic [HNDL_W-1:0] handle);
    req_t r;
    r.req_type = op;
    r.node_id = node;
    r.cost = cost;
    r.record_handle = handle;
    return r;
  endfunction

  function automatic logic [NODE_W-1:0] pick_node();
    if ($urandom_range(15) == 0) return NODE_W'($urandom);
    return NODE_W'($urandom_range(NODE_POOL - 1));
  endfunction

  // Costs mostly from few distinct integers give plenty of ties; one case is any 32-bit value.
  function automatic logic [COST_W-1:0] pick_cost();
    case ($urandom_range(3))
      0:       return {13'd0, 3'($urandom_range(7)), 16'h0};
      1:       return COST_W'($urandom);
      2:       return COST_W'($urandom_range(255)) << 12;
      default: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
    endcase
  endfunction

  // Hold valid across back-to-back items; lower it only for an idle cycle.
  task automatic send_item(input req_t r);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (!in_ready);
    op_seen[r.req_type]++;
    sent++;
  endtask

  task automatic run_directed();
    send_item(make_req(REQ_POP, 16'h0000, 32'h0, 16'h0));
    send_item(make_req(REQ_REMOVE, 16'h0003, 32'h0, 16'h0));
    send_item(make_req(REQ_FIND, 16'h0003, 32'h0, 16'h0));
    send_item(make_req(REQ_ADD, 16'h0000, 32'h0000_0000, 16'h0000));
    send_item(make_req(REQ_ADD, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF));
    send_item(make_req(REQ_ADD, 16'h0005, 32'h0001_0000, 16'h1234));
    send_item(make_req(REQ_ADD, 16'h0006, 32'h0001_0000, 16'hABCD));
    send_item(make_req(REQ_ADD, 16'h0007, 32'h0000_0000, 16'h5555));
    send_item(make_req(REQ_FIND, 16'h0005, 32'h0, 16'h0));
    send_item(make_req(REQ_FIND, 16'hFFFF, 32'h0, 16'h0));
    send_item(make_req(REQ_FIND, 16'h0009, 32'h0, 16'h0));
    send_item(make_req(REQ_REMOVE, 16'h0009, 32'h0, 16'h0));
    send_item(make_req(REQ_ADD, 16'h0005, 32'h0000_0000, 16'h4321));
    send_item(make_req(REQ_ADD, 16'hFFFF, 32'h0000_8000, 16'h0001));
    send_item(make_req(REQ_REMOVE, 16'h0006, 32'h0, 16'h0));
    send_item(make_req(REQ_POP, 16'h0000, 32'h0, 16'h0));
    send_item(make_req(REQ_SPARE_A, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF));
    send_item(make_req(REQ_SPARE_B, 16'h0000, 32'h0, 16'h0));
    send_item(make_req(REQ_SPARE_C, 16'h0005, 32'h0001_0000, 16'h0));
    send_item(make_req(REQ_CLEAR, 16'h0000, 32'h0, 16'h0));
    send_item(make_req(REQ_POP, 16'h0000, 32'h0, 16'h0));
    send_item(make_req(REQ_FIND, 16'h0005, 32'h0, 16'h0));
  endtask

  // Fill: a run of distinct nodes that overflows the list, with replaces mixed in.
  // Drain: mostly pops down to empty. Mixed: everything.
  task automatic run_segment(input seg_kind_t kind);
    int               len;
    int               base;
    int               roll;
    logic [2:0]       op;
    logic [NODE_W-1:0] node;
    base = $urandom_range(NODE_POOL - 1);
    case (kind)
      SEG_FILL:  len = $urandom_range(90, 110);
      SEG_DRAIN: len = $urandom_range(80, 110);
      default:   len = $urandom_range(30, 60);
    endcase
    for (int i = 0; i < len; i++) begin
      roll = $urandom_range(99);
      node = pick_node();
      case (kind)
        SEG_FILL: begin
          if (roll < 80) begin
            op = REQ_ADD;
            if (roll >= 4) node = NODE_W'((base + i) % NODE_POOL);
          end else if (roll < 88) begin
            op = REQ_ADD;
            node = NODE_W'((base + $urandom_range(i)) % NODE_POOL);
          end else if (roll < 95) begin
            op = REQ_FIND;
          end else begin
            op = REQ_REMOVE;
          end
        end
        SEG_DRAIN: begin
          if (roll < 65) op = REQ_POP;
          else if (roll < 88) op = REQ_REMOVE;
          else if (roll < 96) op = REQ_FIND;
          else op = REQ_ADD;
        end
        default: begin
          if (roll < 35) op = REQ_ADD;
          else if (roll < 50) op = REQ_REMOVE;
          else if (roll < 70) op = REQ_FIND;
          else if (roll < 88) op = REQ_POP;
          else if (roll < 93) op = REQ_CLEAR;
          else if (roll < 95) op = REQ_SPARE_A;
          else if (roll < 97) op = REQ_SPARE_B;
          else op = REQ_SPARE_C;
        end
      endcase
      send_item(make_req(op, node, pick_cost(), HNDL_W'($urandom)));
    end
  endtask

  initial begin
    int seg;
    int waited;
    seg = 0;
    waited = 0;
    foreach (op_seen[k]) op_seen[k] = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          in_idle_pct = 36;
          out_idle_pct <= 63;
        end
        1: begin
          in_idle_pct = 63;
          out_idle_pct <= 36;
        end
        default: begin
          in_idle_pct = 0;
          out_idle_pct <= 0;
          hold_req <= 1'b1;
        end
      endcase
      if (ph == 0) run_directed();
      while (sent < (ph + 1) * ITEM_TARGET / 3) begin
        run_segment(seg_kind_t'(seg % 3));
        seg++;
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    $display("sent %0d requests: %0d add, %0d remove, %0d find, %0d pop, %0d clear, %0d spare",
             sent, op_seen[REQ_ADD], op_seen[REQ_REMOVE], op_seen[REQ_FIND], op_seen[REQ_POP],
             op_seen[REQ_CLEAR],
             op_seen[REQ_SPARE_A] + op_seen[REQ_SPARE_B] + op_seen[REQ_SPARE_C]);
    $display("%0d results compared, %0d mismatches, %0d still outstanding",
             compared_count, fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[files.f]
hdl/solq_pkg.sv
hdl/solq_dp.sv
hdl/solq_ctrl.sv
hdl/sorted_open_list_queue.sv
sim/sorted_open_list_queue_check.sv
sim/sorted_open_list_queue_test.sv
